@@ hw/rtl/m4au_pkg.sv @@
// m4au_pkg: shared constants and types for the 4x4 fixed-point matrix unit
// no dependencies; imported by every module of the block except m4au_ram
package m4au_pkg;

    localparam int DIM        = 4;
    localparam int FRAC_BITS  = 16;
    localparam int ELEMS      = DIM * DIM;
    localparam int IDX_W      = 4;
    localparam int DIM_W      = 2;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 66;
    localparam int QUO_W      = 48;

    localparam logic [2:0] FUNC_MUL = 3'd0;
    localparam logic [2:0] FUNC_ADD = 3'd1;
    localparam logic [2:0] FUNC_SUB = 3'd2;
    localparam logic [2:0] FUNC_SCL = 3'd3;
    localparam logic [2:0] FUNC_DIV = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic             clear_acc;   // start a new element
        logic             mac_en;      // accumulate one product term
        logic             div_start;   // load divider
        logic             div_step;    // one quotient bit
        logic             finish;      // saturate and load output register
        logic [2:0]       func;
        logic [IDX_W-1:0] elem;        // current result element
        logic [DIM_W-1:0] k;           // inner product term
    } m4au_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;                // output register still holds a word
    } m4au_stat_t;

endpackage

@@ hw/rtl/m4au_ram.sv @@
// m4au_ram: generic single-write, single-read ram with registered read
// no dependencies
module m4au_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ hw/rtl/m4au_datapath.sv @@
// m4au_datapath: operand stores, multiply-accumulate, bit-serial divider, output register
// depends on m4au_pkg and m4au_ram
module m4au_datapath
    import m4au_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_wr,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic signed [DATA_W-1:0] in_lhs,
    input  logic signed [DATA_W-1:0] in_rhs,
    input  m4au_cmd_t                cmd,
    output m4au_stat_t               stat,
    output logic [DATA_W-1:0]        out_value,
    output logic [IDX_W-1:0]         out_index,
    output logic                     out_last,
    output logic                     out_ovf,
    output logic                     out_dz,
    output logic                     out_valid,
    input  logic                     out_ready
);
    logic [IDX_W-1:0] rd_a, rd_b;
    logic signed [DATA_W-1:0] a_q, b_q;
    logic [DIM_W-1:0] row, col;

    assign row = cmd.elem[DIM_W-1:0];
    assign col = cmd.elem[IDX_W-1:DIM_W];

    always_comb begin
        if (cmd.func == FUNC_MUL) begin
            rd_a = {cmd.k, row};
            rd_b = {col, cmd.k};
        end else begin
            rd_a = cmd.elem;
            rd_b = cmd.elem;
        end
    end

    m4au_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_left (
        .aclk(aclk), .wr_en(in_wr), .wr_addr(in_idx), .wr_data(in_lhs),
        .rd_addr(rd_a), .rd_data(a_q)
    );
    m4au_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_right (
        .aclk(aclk), .wr_en(in_wr), .wr_addr(in_idx), .wr_data(in_rhs),
        .rd_addr(rd_b), .rd_data(b_q)
    );

    // product register then accumulate
    logic signed [2*DATA_W-1:0] prod_reg;
    logic                       prod_vld_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;

    always_ff @(posedge aclk) begin
        prod_reg <= a_q * b_q;
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mac_en;
        end
        acc_reg <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.clear_acc) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg >>> FRAC_BITS);
        end else if (cmd.func == FUNC_ADD) begin
            acc_next = ACC_W'(a_q) + ACC_W'(b_q);
        end else if (cmd.func == FUNC_SUB) begin
            acc_next = ACC_W'(a_q) - ACC_W'(b_q);
        end
    end

    // restoring divider on magnitudes, one quotient bit per step
    logic [QUO_W-1:0]  dvd_reg, quo_reg;
    logic [DATA_W:0]   rem_reg, dvs_reg;
    logic              neg_reg, dz_reg, aneg_reg;
    logic [DATA_W:0]   trial;

    assign trial = {rem_reg[DATA_W-1:0], dvd_reg[QUO_W-1]} - dvs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg  <= {(a_q[DATA_W-1] ? 32'(-a_q) : 32'(a_q)), 16'd0};
            dvs_reg  <= {1'b0, (b_q[DATA_W-1] ? 32'(-b_q) : 32'(b_q))};
            rem_reg  <= '0;
            quo_reg  <= '0;
            neg_reg  <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
            aneg_reg <= a_q[DATA_W-1];
            dz_reg   <= (b_q == 0);
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            if (!trial[DATA_W]) begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[DATA_W-1:0], dvd_reg[QUO_W-1]};
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    // final value and saturation
    logic signed [ACC_W-1:0] fin;
    logic [DATA_W-1:0]       sat_val;
    logic                    sat_ovf, fin_dz;

    always_comb begin
        fin    = acc_reg;
        fin_dz = 1'b0;
        if (cmd.func == FUNC_DIV) begin
            fin = neg_reg ? -ACC_W'(quo_reg) : ACC_W'(quo_reg);
        end
        sat_ovf = 1'b0;
        if (fin > ACC_W'(33'sh0_7FFF_FFFF)) begin
            sat_val = 32'h7FFF_FFFF;
            sat_ovf = 1'b1;
        end else if (fin < -ACC_W'(33'sh0_8000_0000)) begin
            sat_val = 32'h8000_0000;
            sat_ovf = 1'b1;
        end else begin
            sat_val = fin[DATA_W-1:0];
        end
        if (cmd.func == FUNC_DIV && dz_reg) begin
            sat_val = aneg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat_ovf = 1'b0;
            fin_dz  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (cmd.finish) begin
            out_valid <= 1'b1;
        end else if (out_ready) begin
            out_valid <= 1'b0;
        end
        if (cmd.finish) begin
            out_value <= sat_val;
            out_index <= cmd.elem;
            out_last  <= (cmd.elem == IDX_W'(ELEMS - 1));
            out_ovf   <= sat_ovf;
            out_dz    <= fin_dz;
        end
    end

    assign stat.out_busy = out_valid && !out_ready;

`ifndef SYNTH
    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(out_valid && !out_ready))
        else $error("finish while output register full");
    a_dz_only_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_dz) |-> !out_ovf)
        else $error("overflow and zero divisor flagged together");
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_last) |-> (out_index == IDX_W'(ELEMS - 1)))
        else $error("last flag on wrong element");
`endif
endmodule

@@ hw/rtl/m4au_ctrl.sv @@
// m4au_ctrl: sequencer for load, compute and emit of the matrix unit
// depends on m4au_pkg
module m4au_ctrl
    import m4au_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_fire,
    input  logic [2:0]       in_func,
    input  logic [IDX_W-1:0] in_idx,
    output logic             in_ready,
    output m4au_cmd_t        cmd,
    input  m4au_stat_t       stat
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;  // address presented, ram reading
    localparam logic [2:0] ST_OP   = 3'd2;  // operands available
    localparam logic [2:0] ST_MAC  = 3'd3;  // drain product pipeline
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       func_reg, func_next;
    logic [IDX_W-1:0] elem_reg, elem_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [5:0]       cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            func_reg  <= FUNC_MUL;
            elem_reg  <= '0;
            k_reg     <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            func_reg  <= func_next;
            elem_reg  <= elem_next;
            k_reg     <= k_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        func_next  = func_reg;
        elem_next  = elem_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.func   = func_reg;
        cmd.elem   = elem_reg;
        cmd.k      = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_idx == IDX_W'(ELEMS - 1) && in_func <= FUNC_DIV) begin
                    func_next  = in_func;
                    elem_next  = '0;
                    k_next     = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cmd.clear_acc = (k_reg == '0);
                state_next    = ST_OP;
            end
            ST_OP: begin
                unique case (func_reg)
                    FUNC_MUL, FUNC_SCL: begin
                        cmd.mac_en = 1'b1;
                        if (func_reg == FUNC_MUL && k_reg != DIM_W'(DIM - 1)) begin
                            k_next     = k_reg + 1'b1;
                            state_next = ST_RD;
                        end else begin
                            state_next = ST_MAC;
                        end
                    end
                    FUNC_DIV: begin
                        cmd.div_start = 1'b1;
                        cnt_next      = 6'(QUO_W);
                        state_next    = ST_DIV;
                    end
                    default: state_next = ST_FIN;
                endcase
            end
            ST_MAC: begin
                state_next = ST_FIN;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == 6'd1) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    k_next     = '0;
                    if (elem_reg == IDX_W'(ELEMS - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        elem_next  = elem_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_mac_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mac_en |-> (func_reg == FUNC_MUL || func_reg == FUNC_SCL))
        else $error("accumulate for wrong operation");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (state_reg == ST_DIV))
        else $error("divider not stepped after start");
`endif
endmodule

@@ hw/rtl/matrix4_arithmetic_unit.sv @@
// matrix4_arithmetic_unit: top level of the 4x4 Q16.16 matrix unit
// depends on m4au_pkg, m4au_ctrl and m4au_datapath
//
// usage:
//  - s_ words carry one lhs/rhs element pair each, stored at element_index
//    (column*4+row); a word at index 15 with func 0..4 starts the operation
//  - ops: multiply, add, subtract, scale (rhs scalar repeated), divide
//  - m_ words return 16 result elements in index order, tlast on the sixteenth
//  - a loading word is taken while idle; s_tready drops while results are computed
//  - per result: add/sub read, operate and finish; scale also drains the product
//    register; multiply runs four terms through one multiplier and accumulator;
//    divide runs the 48-step bit-serial divider
//  - saturation to 0x7fffffff/0x80000000 sets the overflow flag; a zero divisor
//    saturates by the dividend's sign and sets the divide-by-zero flag
//  - if the receiver stalls, the output register holds the word and the
//    sequencer waits; nothing is dropped
//  - reset (aresetn low, synchronous) returns to idle and empties the output;
//    the element stores are not cleared
module matrix4_arithmetic_unit
    import m4au_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // element_index[3:0], lhs_element[35:4], rhs_element[67:36]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result_value[31:0], result_index[35:32], overflow_flag[36],
                                   // divide_by_zero_flag[37]
    output logic        m_tlast    // last_result
);
    m4au_cmd_t  cmd;
    m4au_stat_t stat;
    logic       in_fire;
    logic [DATA_W-1:0] r_val;
    logic [IDX_W-1:0]  r_idx;
    logic              r_ovf, r_dz;

    assign in_fire = s_tvalid && s_tready;

    m4au_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_func(s_tuser),
        .in_idx(s_tdata[3:0]), .in_ready(s_tready), .cmd(cmd), .stat(stat)
    );

    m4au_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_wr(in_fire), .in_idx(s_tdata[3:0]),
        .in_lhs(s_tdata[35:4]), .in_rhs(s_tdata[67:36]), .cmd(cmd), .stat(stat),
        .out_value(r_val), .out_index(r_idx), .out_last(m_tlast), .out_ovf(r_ovf),
        .out_dz(r_dz), .out_valid(m_tvalid), .out_ready(m_tready)
    );

    assign m_tdata = {2'b00, r_dz, r_ovf, r_idx, r_val};

`ifndef SYNTH
    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped under stall");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed under stall");
    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready || m_tlast)
        else $error("input taken during emit");
`endif
endmodule

@@ tb/matrix4_arithmetic_unit_checker.sv @@
// matrix4_arithmetic_unit_checker: watches both streams of the matrix unit,
// predicts the result words in fixed point and compares them; uses m4au_pkg
`timescale 1ns / 100ps

module matrix4_arithmetic_unit_checker
    import m4au_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_count
);

    typedef struct packed {
        logic [31:0] value;
        logic [3:0]  index;
        logic        last;
        logic        ovf;
        logic        dz;
    } result_word_t;

    logic signed [31:0] lhs_mem [ELEMS];
    logic signed [31:0] rhs_mem [ELEMS];
    result_word_t       expected_results [$];

    assign pending_count = expected_results.size();

    function automatic logic signed [63:0] q_product(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic [31:0] clamp_q(logic signed [67:0] v, output logic ovf);
        ovf = 1'b0;
        if (v > 68'sh7fffffff) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -68'sh80000000) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // one full operation over the stored matrices
    task automatic compute_matrix_op(logic [2:0] op);
        logic signed [67:0] acc;
        logic signed [63:0] num;
        logic signed [63:0] den;
        result_word_t       w;
        for (int i = 0; i < ELEMS; i++) begin
            w = '0;
            w.index = 4'(i);
            w.last = (i == ELEMS - 1);
            case (op)
                FUNC_MUL: begin
                    acc = '0;
                    for (int k = 0; k < DIM; k++)
                        acc += 68'(q_product(lhs_mem[k*DIM + i%DIM], rhs_mem[(i/DIM)*DIM + k]));
                    w.value = clamp_q(acc, w.ovf);
                end
                FUNC_ADD: w.value = clamp_q(68'(lhs_mem[i]) + 68'(rhs_mem[i]), w.ovf);
                FUNC_SUB: w.value = clamp_q(68'(lhs_mem[i]) - 68'(rhs_mem[i]), w.ovf);
                FUNC_SCL: w.value = clamp_q(68'(q_product(lhs_mem[i], rhs_mem[i])), w.ovf);
                default: begin
                    if (rhs_mem[i] == 0) begin
                        w.dz = 1'b1;
                        w.value = lhs_mem[i] < 0 ? 32'h80000000 : 32'h7fffffff;
                    end else begin
                        num = 64'(lhs_mem[i]) <<< FRAC_BITS;
                        den = 64'(rhs_mem[i]);
                        w.value = clamp_q(68'(num / den), w.ovf);
                    end
                end
            endcase
            expected_results.push_back(w);
        end
    endtask

    always @(posedge aclk) begin
        result_word_t got;
        result_word_t want;
        logic [3:0]   idx;
        if (!aresetn) begin
            mismatch_count <= 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                idx = s_tdata[3:0];
                lhs_mem[idx] = s_tdata[35:4];
                rhs_mem[idx] = s_tdata[67:36];
                if (idx == ELEMS - 1 && s_tuser <= FUNC_DIV)
                    compute_matrix_op(s_tuser);
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[35:32], m_tlast, m_tdata[36], m_tdata[37]};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, got);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: word mismatch, expected val %h idx %0d last %b ovf %b dz %b",
                                 $time, want.value, want.index, want.last, want.ovf, want.dz);
                        $display("%0t:                actual   val %h idx %0d last %b ovf %b dz %b",
                                 $time, got.value, got.index, got.last, got.ovf, got.dz);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/matrix4_arithmetic_unit_tb.sv @@
// matrix4_arithmetic_unit_tb: drives element pairs into the matrix unit with random
// gaps and stalls; depends on m4au_pkg, the block and matrix4_arithmetic_unit_checker
`timescale 1ns / 100ps

module matrix4_arithmetic_unit_tb;
    import m4au_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          mismatch_count;
    int          pending_count;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;   // long stretch where neither side idles

    localparam int WATCHDOG_LIMIT = 20000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    matrix4_arithmetic_unit u_top (.*);

    matrix4_arithmetic_unit_checker u_checker (.*);

    // receiver stalls at random with probability 35/100, except in the no-gap stretch
    always @(negedge aclk)
        m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 35);

    // cycles with no accepted word on either side; past the watchdog limit the run ends
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one element pair; random gap before it unless no_gaps is set, then hold until accepted
    task automatic send_word(logic [2:0] op, logic [3:0] idx, logic [31:0] lhs, logic [31:0] rhs);
        while (!no_gaps && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= {4'b0, rhs, lhs, idx};
        s_tuser <= op;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_value(int shape);
        case (shape)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);  // near unity
            2: return {$urandom_range(1) ? 32'h7fffffff : 32'h80000000};
            default: return $urandom_range(3) == 0 ? 32'h0 : 32'($urandom_range(0, 32'h7ffff));
        endcase
    endfunction

    // full set of 16 pairs, operation taken from the last one
    task automatic send_matrix(logic [2:0] op, int shape, bit shuffle);
        logic [31:0] scalar;
        int          order [ELEMS];
        int          j, t;
        scalar = rand_value(shape);
        for (int i = 0; i < ELEMS; i++)
            order[i] = i;
        if (shuffle)
            for (int i = 0; i < ELEMS - 1; i++) begin
                j = $urandom_range(i, ELEMS - 2);
                t = order[i]; order[i] = order[j]; order[j] = t;
            end
        for (int i = 0; i < ELEMS; i++)
            send_word(i == ELEMS - 1 ? op : 3'($urandom_range(7)), 4'(order[i]),
                      rand_value(shape),
                      (op == FUNC_SCL || op == FUNC_DIV) ? scalar : rand_value(shape));
    endtask

    initial begin
        logic [2:0] op;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every operation, zero divisor with a zero dividend
        for (int i = 0; i < ELEMS; i++)
            send_word(FUNC_ADD, 4'(i), i[0] ? 32'h80000000 : 32'h7fffffff,
                      i[1] ? 32'h7fffffff : 32'h80000000);
        send_word(FUNC_SUB, 4'(ELEMS - 1), 32'h80000000, 32'h7fffffff);
        send_word(FUNC_MUL, 4'(ELEMS - 1), 32'hffffffff, 32'h00000000);
        send_word(FUNC_SCL, 4'(ELEMS - 1), 32'h80000000, 32'h80000000);
        send_word(FUNC_DIV, 4'(ELEMS - 1), 32'h00000000, 32'h00000000);
        send_word(3'd5, 4'(ELEMS - 1), 32'h1, 32'h1);   // unknown operation, stored only
        send_word(3'd7, 4'(ELEMS - 1), 32'h2, 32'h0);
        send_word(FUNC_DIV, 4'(ELEMS - 1), 32'h00010000, 32'h00000001);

        // pause until every result is back
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);

        // random sets: mostly full matrices, some lone words
        for (int n = 0; n < 27; n++) begin
            no_gaps = (n >= 8 && n < 12);
            op = 3'($urandom_range(4));
            if ($urandom_range(9) == 0)
                send_word(3'($urandom_range(7)), 4'($urandom_range(15)),
                          $urandom(), $urandom());
            else
                send_matrix(op, $urandom_range(3), $urandom_range(1));
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_count != 0)
            @(negedge aclk);
        repeat (1000) @(negedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/m4au_pkg.sv
hw/rtl/m4au_ram.sv
hw/rtl/m4au_datapath.sv
hw/rtl/m4au_ctrl.sv
hw/rtl/matrix4_arithmetic_unit.sv
tb/matrix4_arithmetic_unit_checker.sv
tb/matrix4_arithmetic_unit_tb.sv
